@@ rtl/core/fifo_victim_cache_unit_macros.svh @@
// assertion helpers used by the back end rtl
`ifndef FIFO_VICTIM_CACHE_UNIT_MACROS_SVH
`define FIFO_VICTIM_CACHE_UNIT_MACROS_SVH

// same-cycle implication under reset
`define FVC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under reset
`define FVC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/fvc_pkg.sv @@
`default_nettype none
package fvc_pkg;

  localparam int ENTRIES_MAX   = 16;
  localparam int TAG_BITS      = 48;
  localparam int INDEX_BITS    = 16;
  localparam int SUBBLOCK_BITS = 6;

  localparam int AGE_BITS   = (ENTRIES_MAX > 1) ? $clog2(ENTRIES_MAX) : 1;
  localparam int CNT_BITS   = $clog2(ENTRIES_MAX + 1);
  localparam int USED_W     = 5;
  localparam int LOG2_W     = 4;
  localparam int BYTES_W    = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [LOG2_W-1:0] BLOCK_LOG2_LIMIT = LOG2_W'(12);

  localparam logic [USED_W-1:0] ENTRIES_USED_RST  = USED_W'(8);
  localparam logic [LOG2_W-1:0] BLOCK_LOG2_RST    = LOG2_W'(6);
  localparam logic [LOG2_W-1:0] SUBBLOCK_LOG2_RST = LOG2_W'(4);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_USED  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LOG2    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_SUBBLOCK_LOG2 = CFG_IDX_W'(2);

  // request codes on the input
  localparam logic FUNC_SEARCH = 1'b0;
  localparam logic FUNC_INSERT = 1'b1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // classified operation
  typedef enum logic [1:0] {
    OP_LOOKUP,
    OP_INSERT,
    OP_MISS,
    OP_DIRECT
  } fvc_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEL,
    ST_UPD
  } fvc_state_t;

  typedef struct packed {
    fvc_op_t                  op;
    logic [TAG_BITS-1:0]      tag;
    logic [INDEX_BITS-1:0]    index;
    logic                     dirty;
    logic [SUBBLOCK_BITS-1:0] first_valid;
  } fvc_req_t;

  typedef struct packed {
    logic [CNT_BITS-1:0] used;
    logic [LOG2_W-1:0]   blk;
    logic [LOG2_W-1:0]   sub;
  } fvc_cfg_t;

  // write-back size: (2^(b-k) - first_valid) << k, zero when negative
  function automatic logic [BYTES_W-1:0] wb_byte_count(
    input logic [SUBBLOCK_BITS-1:0] fv,
    input logic [LOG2_W-1:0]        blk,
    input logic [LOG2_W-1:0]        sub
  );
    logic [LOG2_W-1:0]  b;
    logic [LOG2_W-1:0]  k;
    logic [BYTES_W-1:0] n;
    logic [BYTES_W-1:0] fv_w;
    logic [BYTES_W-1:0] res;
    b    = (blk > BLOCK_LOG2_LIMIT) ? BLOCK_LOG2_LIMIT : blk;
    k    = (sub > b) ? b : sub;
    n    = BYTES_W'(1) << (b - k);
    fv_w = BYTES_W'(fv);
    if (fv_w >= n) begin
      res = '0;
    end else begin
      res = (n - fv_w) << k;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/fvc_front.sv @@
`default_nettype none
module fvc_front (
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              in_func,
  input  wire logic [fvc_pkg::TAG_BITS-1:0]      in_tag_in,
  input  wire logic [fvc_pkg::INDEX_BITS-1:0]    in_set_index,
  input  wire logic                              in_dirty_in,
  input  wire logic [fvc_pkg::SUBBLOCK_BITS-1:0] in_first_valid_in,
  input  wire logic                              used_zero,
  output logic                                   push_valid,
  input  wire logic                              push_ready,
  output fvc_pkg::fvc_req_t                      push_req
);
  import fvc_pkg::*;

  fvc_op_t op;

  // a disabled cache never looks anything up
  always_comb begin
    if (in_func == FUNC_INSERT) begin
      op = used_zero ? OP_DIRECT : OP_INSERT;
    end else begin
      op = used_zero ? OP_MISS : OP_LOOKUP;
    end
  end

  assign push_req.op          = op;
  assign push_req.tag         = in_tag_in;
  assign push_req.index       = in_set_index;
  assign push_req.dirty       = in_dirty_in;
  assign push_req.first_valid = in_first_valid_in;

  assign push_valid = in_valid;
  assign in_ready   = push_ready;

endmodule
`default_nettype wire

@@ rtl/core/fvc_queue.sv @@
`default_nettype none
module fvc_queue (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push_valid,
  output logic              push_ready,
  input  wire fvc_pkg::fvc_req_t push_req,
  output logic              pop_valid,
  input  wire logic         pop_ready,
  output fvc_pkg::fvc_req_t pop_req
);
  import fvc_pkg::*;

  fvc_req_t          slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r;
  logic [QCNT_W-1:0] cnt_nxt;
  logic              push;
  logic              pop;

  assign push_ready = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_req    = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    cnt_nxt = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_req;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/fvc_back.sv @@
`default_nettype none
`include "fifo_victim_cache_unit_macros.svh"
module fvc_back (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire fvc_pkg::fvc_cfg_t                 cfg,
  input  wire logic                              pop_valid,
  output logic                                   pop_ready,
  input  wire fvc_pkg::fvc_req_t                 pop_req,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   out_hit,
  output logic                                   out_hit_dirty,
  output logic [fvc_pkg::SUBBLOCK_BITS-1:0]      out_hit_first_valid,
  output logic                                   out_wrote_back,
  output logic [fvc_pkg::TAG_BITS-1:0]           out_wb_tag,
  output logic [fvc_pkg::INDEX_BITS-1:0]         out_wb_index,
  output logic [fvc_pkg::BYTES_W-1:0]            out_wb_bytes
);
  import fvc_pkg::*;

  // entry store
  logic [ENTRIES_MAX-1:0]   valid_r;
  logic [ENTRIES_MAX-1:0]   valid_nxt;
  logic [AGE_BITS-1:0]      age_r [ENTRIES_MAX];
  logic [AGE_BITS-1:0]      age_nxt [ENTRIES_MAX];
  logic [TAG_BITS-1:0]      tag_r [ENTRIES_MAX];
  logic [INDEX_BITS-1:0]    index_r [ENTRIES_MAX];
  logic                     dirty_r [ENTRIES_MAX];
  logic [SUBBLOCK_BITS-1:0] fv_r [ENTRIES_MAX];

  // sequencer
  fvc_state_t state_r;
  fvc_state_t state_nxt;
  fvc_req_t   item_r;
  logic       load_item;
  logic       upd_fire;
  logic       out_free;

  // select stage
  logic [ENTRIES_MAX-1:0] match;
  logic [ENTRIES_MAX-1:0] newest_oh;
  logic [ENTRIES_MAX-1:0] oldest_oh;
  logic [ENTRIES_MAX-1:0] free_oh;
  logic [CNT_BITS-1:0]    count;
  logic                   full;
  logic [ENTRIES_MAX-1:0] sel_oh_nxt;
  logic [AGE_BITS-1:0]    sel_age_nxt;
  logic [ENTRIES_MAX-1:0] sel_oh_r;
  logic [AGE_BITS-1:0]    sel_age_r;
  logic                   found_r;
  logic                   evict_r;

  // update stage
  logic [TAG_BITS-1:0]      rd_tag;
  logic [INDEX_BITS-1:0]    rd_index;
  logic                     rd_dirty;
  logic [SUBBLOCK_BITS-1:0] rd_fv;
  logic [SUBBLOCK_BITS-1:0] bytes_fv;

  logic                     out_valid_r;
  logic                     out_valid_nxt;
  logic                     hit_nxt;
  logic                     hit_dirty_nxt;
  logic [SUBBLOCK_BITS-1:0] hit_fv_nxt;
  logic                     wb_nxt;
  logic [TAG_BITS-1:0]      wb_tag_nxt;
  logic [INDEX_BITS-1:0]    wb_index_nxt;
  logic [BYTES_W-1:0]       wb_bytes_nxt;
  logic                     hit_r;
  logic                     hit_dirty_r;
  logic [SUBBLOCK_BITS-1:0] hit_fv_r;
  logic                     wb_r;
  logic [TAG_BITS-1:0]      wb_tag_r;
  logic [INDEX_BITS-1:0]    wb_index_r;
  logic [BYTES_W-1:0]       wb_bytes_r;

  assign out_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (pop_valid) state_nxt = ST_SEL;
      ST_SEL:  state_nxt = ST_UPD;
      ST_UPD: begin
        if (out_free) state_nxt = pop_valid ? ST_SEL : ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    upd_fire  = 1'b0;
    pop_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: pop_ready = 1'b1;
      ST_SEL:  pop_ready = 1'b0;
      ST_UPD: begin
        upd_fire  = out_free;
        pop_ready = out_free;
      end
      default: pop_ready = 1'b0;
    endcase
  end

  assign load_item = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_item) begin
      item_r <= pop_req;
    end
  end

  // parallel tag compare, newest match, oldest and first free entry
  always_comb begin
    for (int i = 0; i < ENTRIES_MAX; i++) begin
      match[i] = valid_r[i] && (tag_r[i] == item_r.tag) && (index_r[i] == item_r.index);
    end
  end

  always_comb begin
    for (int i = 0; i < ENTRIES_MAX; i++) begin
      newest_oh[i] = match[i];
      for (int j = 0; j < ENTRIES_MAX; j++) begin
        if (match[j] && (age_r[j] < age_r[i])) newest_oh[i] = 1'b0;
      end
    end
  end

  assign count   = CNT_BITS'($countones(valid_r));
  assign full    = (count >= cfg.used);
  assign free_oh = ~valid_r & (valid_r + ENTRIES_MAX'(1));

  always_comb begin
    for (int i = 0; i < ENTRIES_MAX; i++) begin
      oldest_oh[i] = valid_r[i] && (age_r[i] == AGE_BITS'(count - CNT_BITS'(1)));
    end
  end

  always_comb begin
    if (item_r.op == OP_LOOKUP) begin
      sel_oh_nxt = newest_oh;
    end else begin
      sel_oh_nxt = full ? oldest_oh : free_oh;
    end
    sel_age_nxt = '0;
    for (int i = 0; i < ENTRIES_MAX; i++) begin
      if (sel_oh_nxt[i]) sel_age_nxt = sel_age_nxt | age_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_SEL) begin
      sel_oh_r  <= (item_r.op == OP_LOOKUP || item_r.op == OP_INSERT) ? sel_oh_nxt : '0;
      sel_age_r <= sel_age_nxt;
      found_r   <= (item_r.op == OP_LOOKUP) && (|newest_oh);
      evict_r   <= (item_r.op == OP_INSERT) && full;
    end
  end

  // read of the selected entry
  always_comb begin
    rd_tag   = '0;
    rd_index = '0;
    rd_dirty = 1'b0;
    rd_fv    = '0;
    for (int i = 0; i < ENTRIES_MAX; i++) begin
      if (sel_oh_r[i]) begin
        rd_tag   = rd_tag | tag_r[i];
        rd_index = rd_index | index_r[i];
        rd_dirty = rd_dirty | dirty_r[i];
        rd_fv    = rd_fv | fv_r[i];
      end
    end
  end

  assign bytes_fv = (item_r.op == OP_DIRECT) ? item_r.first_valid : rd_fv;

  // result of the item
  always_comb begin
    hit_nxt       = 1'b0;
    hit_dirty_nxt = 1'b0;
    hit_fv_nxt    = '0;
    wb_nxt        = 1'b0;
    wb_tag_nxt    = '0;
    wb_index_nxt  = '0;
    wb_bytes_nxt  = '0;
    unique case (item_r.op)
      OP_LOOKUP: begin
        if (found_r) begin
          hit_nxt       = 1'b1;
          hit_dirty_nxt = rd_dirty;
          hit_fv_nxt    = rd_fv;
        end
      end
      OP_INSERT: begin
        if (evict_r && rd_dirty) begin
          wb_nxt       = 1'b1;
          wb_tag_nxt   = rd_tag;
          wb_index_nxt = rd_index;
          wb_bytes_nxt = wb_byte_count(bytes_fv, cfg.blk, cfg.sub);
        end
      end
      OP_DIRECT: begin
        if (item_r.dirty) begin
          wb_nxt       = 1'b1;
          wb_tag_nxt   = item_r.tag;
          wb_index_nxt = item_r.index;
          wb_bytes_nxt = wb_byte_count(bytes_fv, cfg.blk, cfg.sub);
        end
      end
      OP_MISS: hit_nxt = 1'b0;
      default: hit_nxt = 1'b0;
    endcase
  end

  // entry valid and age update
  always_comb begin
    valid_nxt = valid_r;
    for (int i = 0; i < ENTRIES_MAX; i++) begin
      age_nxt[i] = age_r[i];
    end
    if (upd_fire && item_r.op == OP_LOOKUP && found_r) begin
      for (int i = 0; i < ENTRIES_MAX; i++) begin
        if (sel_oh_r[i]) begin
          valid_nxt[i] = 1'b0;
          age_nxt[i]   = '0;
        end else if (valid_r[i] && (age_r[i] > sel_age_r)) begin
          age_nxt[i] = age_r[i] - AGE_BITS'(1);
        end
      end
    end else if (upd_fire && item_r.op == OP_INSERT) begin
      for (int i = 0; i < ENTRIES_MAX; i++) begin
        if (sel_oh_r[i]) begin
          valid_nxt[i] = 1'b1;
          age_nxt[i]   = '0;
        end else if (valid_r[i]) begin
          age_nxt[i] = age_r[i] + AGE_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      for (int i = 0; i < ENTRIES_MAX; i++) begin
        age_r[i] <= '0;
      end
    end else begin
      valid_r <= valid_nxt;
      for (int i = 0; i < ENTRIES_MAX; i++) begin
        age_r[i] <= age_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES_MAX; i++) begin
      if (upd_fire && item_r.op == OP_INSERT && sel_oh_r[i]) begin
        tag_r[i]   <= item_r.tag;
        index_r[i] <= item_r.index;
        dirty_r[i] <= item_r.dirty;
        fv_r[i]    <= item_r.first_valid;
      end
    end
  end

  // output register
  assign out_valid_nxt = upd_fire || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_fire) begin
      hit_r       <= hit_nxt;
      hit_dirty_r <= hit_dirty_nxt;
      hit_fv_r    <= hit_fv_nxt;
      wb_r        <= wb_nxt;
      wb_tag_r    <= wb_tag_nxt;
      wb_index_r  <= wb_index_nxt;
      wb_bytes_r  <= wb_bytes_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_hit             = hit_r;
  assign out_hit_dirty       = hit_dirty_r;
  assign out_hit_first_valid = hit_fv_r;
  assign out_wrote_back      = wb_r;
  assign out_wb_tag          = wb_tag_r;
  assign out_wb_index        = wb_index_r;
  assign out_wb_bytes        = wb_bytes_r;

  `FVC_ASSERT_SAME(a_insert_one_slot, clk, rst_n, (state_r == ST_UPD) && (item_r.op == OP_INSERT), $onehot(sel_oh_r), "insert without exactly one target entry")
  `FVC_ASSERT_SAME(a_lookup_one_hit, clk, rst_n, (state_r == ST_UPD) && (item_r.op == OP_LOOKUP), $onehot0(sel_oh_r) && (found_r == (|sel_oh_r)), "lookup selected more than one entry")
  `FVC_ASSERT_NEXT(a_upd_loads_out, clk, rst_n, upd_fire, out_valid_r, "finished item not presented")

endmodule
`default_nettype wire

@@ rtl/core/fifo_victim_cache_unit.sv @@
`default_nettype none
// fully associative victim cache of up to 16 entries with fifo replacement.
// a search item (func 0) looks up tag and set index, returns the dirty mark and
// first valid sub-block of the newest match and frees that entry; an insert item
// (func 1) stores the block as the newest entry, evicting the oldest one when the
// entries in use are full and reporting a write-back when it was dirty. every
// item gives exactly one result item (with no entries in use, a search misses and
// an insert reports only its own write-back if dirty). the front end classifies
// items into a two-deep queue, so the input keeps taking items while the back end
// works and the queue has room; the back end runs each item through parallel
// compare and select, then entry update and result load, taking the next item as
// it finishes one. the result sits in an output register; a stall holds the back
// end in its update step. no clearing pass after reset: entries come up invalid at once.
module fifo_victim_cache_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // configuration writes
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [fvc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [fvc_pkg::CFG_DATA_W-1:0]    cfg_data,
  // request items
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              in_func,
  input  wire logic [fvc_pkg::TAG_BITS-1:0]      in_tag_in,
  input  wire logic [fvc_pkg::INDEX_BITS-1:0]    in_set_index,
  input  wire logic                              in_dirty_in,
  input  wire logic [fvc_pkg::SUBBLOCK_BITS-1:0] in_first_valid_in,
  // result items
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   out_hit,
  output logic                                   out_hit_dirty,
  output logic [fvc_pkg::SUBBLOCK_BITS-1:0]      out_hit_first_valid,
  output logic                                   out_wrote_back,
  output logic [fvc_pkg::TAG_BITS-1:0]           out_wb_tag,
  output logic [fvc_pkg::INDEX_BITS-1:0]         out_wb_index,
  output logic [fvc_pkg::BYTES_W-1:0]            out_wb_bytes
);
  import fvc_pkg::*;

  // configuration registers
  logic [USED_W-1:0] entries_used_r;
  logic [LOG2_W-1:0] block_log2_r;
  logic [LOG2_W-1:0] subblock_log2_r;
  logic              cfg_write;
  fvc_cfg_t          cfg_eff;
  logic              used_zero;

  // front to queue, queue to back
  logic     push_valid;
  logic     push_ready;
  fvc_req_t push_req;
  logic     pop_valid;
  logic     pop_ready;
  fvc_req_t pop_req;

  // the user must send writes only while the block is idle; the block does not enforce this and is always ready
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_used_r  <= ENTRIES_USED_RST;
      block_log2_r    <= BLOCK_LOG2_RST;
      subblock_log2_r <= SUBBLOCK_LOG2_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_ENTRIES_USED:  entries_used_r  <= USED_W'(cfg_data);
        CFG_BLOCK_LOG2:    block_log2_r    <= LOG2_W'(cfg_data);
        CFG_SUBBLOCK_LOG2: subblock_log2_r <= LOG2_W'(cfg_data);
        default:           entries_used_r  <= entries_used_r;  // unmapped index
      endcase
    end
  end

  // entries in use above the store size act as the store size
  always_comb begin
    if (int'(entries_used_r) > ENTRIES_MAX) begin
      cfg_eff.used = CNT_BITS'(ENTRIES_MAX);
    end else begin
      cfg_eff.used = CNT_BITS'(entries_used_r);
    end
    cfg_eff.blk = block_log2_r;
    cfg_eff.sub = subblock_log2_r;
  end

  assign used_zero = (entries_used_r == '0);

  fvc_front u_front (
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_tag_in         (in_tag_in),
    .in_set_index      (in_set_index),
    .in_dirty_in       (in_dirty_in),
    .in_first_valid_in (in_first_valid_in),
    .used_zero         (used_zero),
    .push_valid        (push_valid),
    .push_ready        (push_ready),
    .push_req          (push_req)
  );

  fvc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_req   (push_req),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_req    (pop_req)
  );

  fvc_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg_eff),
    .pop_valid           (pop_valid),
    .pop_ready           (pop_ready),
    .pop_req             (pop_req),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_hit             (out_hit),
    .out_hit_dirty       (out_hit_dirty),
    .out_hit_first_valid (out_hit_first_valid),
    .out_wrote_back      (out_wrote_back),
    .out_wb_tag          (out_wb_tag),
    .out_wb_index        (out_wb_index),
    .out_wb_bytes        (out_wb_bytes)
  );

endmodule
`default_nettype wire
